@@ hw/rtl/bpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpsc_pkg: shared types and constants for the button panel calibrator
// Register indexes, reset values, fixed-point weights, job word and helpers.
// ----------------------------------------------------------------------------
package bpsc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam logic [8:0] TABLE_LIMIT = 9'(TABLE_ENTRIES);

	localparam int NUM_BTN   = 5;
	localparam int BTN_FREQ  = 0;
	localparam int BTN_PULSE = 1;
	localparam int BTN_UP    = 2;
	localparam int BTN_DOWN  = 3;
	localparam int BTN_CAL   = 4;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;
	localparam logic [CFG_AW-1:0] CFG_FREQ_COUNT     = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_PULSE_COUNT    = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_DEBOUNCE_TICKS = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_CURRENT_STEP   = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_CURRENT_MIN    = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_CURRENT_MAX    = 3'd5;

	localparam logic [4:0]  RST_FREQ_COUNT     = 5'd4;
	localparam logic [4:0]  RST_PULSE_COUNT    = 5'd4;
	localparam logic [3:0]  RST_DEBOUNCE_TICKS = 4'd3;
	localparam logic [15:0] RST_CURRENT_STEP   = 16'd128;
	localparam logic [15:0] RST_CURRENT_MIN    = 16'd0;
	localparam logic [15:0] RST_CURRENT_MAX    = 16'd5120;

	localparam logic [31:0] GAIN_ONE  = 32'h0100_0000;
	localparam logic [15:0] W_OLD     = 16'd55706;
	localparam logic [13:0] W_NEW     = 14'd9830;
	localparam logic [48:0] MIX_ROUND = 49'd32768;
	localparam logic [23:0] AREA_ONE  = 24'd256;

	localparam int DIV_BITS = 41;
	localparam int DIV_CW   = 6;
	localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_BITS - 1);

	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

	typedef enum logic [1:0] {
		CAL_NONE    = 2'd0,
		CAL_UPDATE  = 2'd1,
		CAL_IGNORED = 2'd2
	} cal_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL_OLD,
		BK_MUL_NEW,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		logic [3:0]  freq_index;
		logic [3:0]  pulse_index;
		logic [15:0] setpoint;
		logic [23:0] area;
		logic        reapply;
		cal_kind_t   cal;
	} job_t;

	typedef struct packed {
		logic pop;
		logic out_load;
		logic div_load;
		logic gain_update;
	} back_ctrl_t;

	function automatic logic [3:0] advance_sel(input logic [3:0] sel, input logic [4:0] count);
		logic [4:0] n;
		n = {1'b0, sel} + 5'd1;
		if (n >= count || {4'd0, n} >= TABLE_LIMIT || n > 5'd15) begin
			return 4'd0;
		end
		return n[3:0];
	endfunction

	function automatic logic [15:0] clamp_sp(input logic signed [17:0] x,
		input logic [15:0] lo, input logic [15:0] hi);
		if (x < $signed({2'b00, lo})) begin
			return lo;
		end
		if (x > $signed({2'b00, hi})) begin
			return hi;
		end
		return x[15:0];
	endfunction

endpackage

@@ hw/rtl/bpsc_front.sv @@
// ----------------------------------------------------------------------------
// bpsc_front: debounce, index and setpoint handling
// Holds the configuration registers and the per-button debouncers, applies
// the index and setpoint actions of each tick and classifies the calibration.
// ----------------------------------------------------------------------------
module bpsc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [bpsc_pkg::CFG_AW-1:0]   cfg_index,
	input  logic [bpsc_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                          accept,
	input  logic                          raw_freq,
	input  logic                          raw_pulse,
	input  logic                          raw_up,
	input  logic                          raw_down,
	input  logic                          raw_cal,
	input  logic [23:0]                   pulse_area,
	output bpsc_pkg::job_t                job
);

	logic [4:0]  freq_count_q;
	logic [4:0]  pulse_count_q;
	logic [3:0]  debounce_ticks_q;
	logic [15:0] current_step_q;
	logic [15:0] current_min_q;
	logic [15:0] current_max_q;

	logic [bpsc_pkg::NUM_BTN-1:0] last_q, last_d;
	logic [bpsc_pkg::NUM_BTN-1:0] stable_q, stable_d;
	logic [3:0] hold_q [bpsc_pkg::NUM_BTN];
	logic [3:0] hold_d [bpsc_pkg::NUM_BTN];
	logic [bpsc_pkg::NUM_BTN-1:0] raw;
	logic [bpsc_pkg::NUM_BTN-1:0] press;

	logic [3:0]  freq_sel_q, freq_sel_d;
	logic [3:0]  pulse_sel_q, pulse_sel_d;
	logic [15:0] setpoint_q, sp_up, sp_dn;
	logic signed [17:0] sum_up, sum_dn;
	bpsc_pkg::cal_kind_t cal_kind;

	assign raw = {raw_cal, raw_down, raw_up, raw_pulse, raw_freq};

	always_comb begin
		for (int b = 0; b < bpsc_pkg::NUM_BTN; b++) begin
			if (raw[b] == last_q[b]) begin
				last_d[b] = last_q[b];
				hold_d[b] = (hold_q[b] < debounce_ticks_q) ? hold_q[b] + 4'd1 : hold_q[b];
			end else begin
				last_d[b] = raw[b];
				hold_d[b] = 4'd0;
			end
			if (hold_d[b] == debounce_ticks_q && stable_q[b] != raw[b]) begin
				stable_d[b] = raw[b];
				press[b]    = raw[b];
			end else begin
				stable_d[b] = stable_q[b];
				press[b]    = 1'b0;
			end
		end
	end

	always_comb begin
		freq_sel_d  = press[bpsc_pkg::BTN_FREQ] ?
			bpsc_pkg::advance_sel(freq_sel_q, freq_count_q) : freq_sel_q;
		pulse_sel_d = press[bpsc_pkg::BTN_PULSE] ?
			bpsc_pkg::advance_sel(pulse_sel_q, pulse_count_q) : pulse_sel_q;
		sum_up = $signed({2'b00, setpoint_q}) + $signed({2'b00, current_step_q});
		sp_up  = press[bpsc_pkg::BTN_UP] ?
			bpsc_pkg::clamp_sp(sum_up, current_min_q, current_max_q) : setpoint_q;
		sum_dn = $signed({2'b00, sp_up}) - $signed({2'b00, current_step_q});
		sp_dn  = press[bpsc_pkg::BTN_DOWN] ?
			bpsc_pkg::clamp_sp(sum_dn, current_min_q, current_max_q) : sp_up;
		if (!press[bpsc_pkg::BTN_CAL]) begin
			cal_kind = bpsc_pkg::CAL_NONE;
		end else if (pulse_area > bpsc_pkg::AREA_ONE) begin
			cal_kind = bpsc_pkg::CAL_UPDATE;
		end else begin
			cal_kind = bpsc_pkg::CAL_IGNORED;
		end
	end

	always_comb begin
		job.freq_index  = freq_sel_d;
		job.pulse_index = pulse_sel_d;
		job.setpoint    = sp_dn;
		job.area        = pulse_area;
		job.reapply     = press[bpsc_pkg::BTN_FREQ] | press[bpsc_pkg::BTN_PULSE];
		job.cal         = cal_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_count_q     <= bpsc_pkg::RST_FREQ_COUNT;
			pulse_count_q    <= bpsc_pkg::RST_PULSE_COUNT;
			debounce_ticks_q <= bpsc_pkg::RST_DEBOUNCE_TICKS;
			current_step_q   <= bpsc_pkg::RST_CURRENT_STEP;
			current_min_q    <= bpsc_pkg::RST_CURRENT_MIN;
			current_max_q    <= bpsc_pkg::RST_CURRENT_MAX;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bpsc_pkg::CFG_FREQ_COUNT:     freq_count_q     <= cfg_data[4:0];
				bpsc_pkg::CFG_PULSE_COUNT:    pulse_count_q    <= cfg_data[4:0];
				bpsc_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[3:0];
				bpsc_pkg::CFG_CURRENT_STEP:   current_step_q   <= cfg_data;
				bpsc_pkg::CFG_CURRENT_MIN:    current_min_q    <= cfg_data;
				bpsc_pkg::CFG_CURRENT_MAX:    current_max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			stable_q    <= '0;
			freq_sel_q  <= 4'd0;
			pulse_sel_q <= 4'd0;
			setpoint_q  <= 16'd0;
			for (int b = 0; b < bpsc_pkg::NUM_BTN; b++) begin
				hold_q[b] <= 4'd0;
			end
		end else if (accept) begin
			last_q      <= last_d;
			stable_q    <= stable_d;
			freq_sel_q  <= freq_sel_d;
			pulse_sel_q <= pulse_sel_d;
			setpoint_q  <= sp_dn;
			for (int b = 0; b < bpsc_pkg::NUM_BTN; b++) begin
				hold_q[b] <= hold_d[b];
			end
		end
	end

endmodule

@@ hw/rtl/bpsc_jobq.sv @@
// ----------------------------------------------------------------------------
// bpsc_jobq: job queue between front and back
// Short first-in first-out buffer of classified tick words.
// ----------------------------------------------------------------------------
module bpsc_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpsc_pkg::job_t wr_data,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output bpsc_pkg::job_t rd_data
);

	bpsc_pkg::job_t mem_q [bpsc_pkg::JOBQ_DEPTH];
	logic [bpsc_pkg::JOBQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [bpsc_pkg::JOBQ_AW:0]   count_q;

	assign full    = (count_q == (bpsc_pkg::JOBQ_AW + 1)'(bpsc_pkg::JOBQ_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

@@ hw/rtl/bpsc_back.sv @@
// ----------------------------------------------------------------------------
// bpsc_back: calibration engine and result register
// Runs the serial divider and the gain blend for calibration jobs, holds the
// gain and presents each finished word on the result register.
// ----------------------------------------------------------------------------
module bpsc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  bpsc_pkg::job_t job,
	output logic           job_pop,
	input  logic           pop,
	output logic           empty,
	output logic [3:0]     freq_index,
	output logic [3:0]     pulse_index,
	output logic [15:0]    current_setpoint,
	output logic [31:0]    area_gain,
	output logic           pwm_reapply,
	output logic [1:0]     cal_status
);

	bpsc_pkg::back_state_t state_q, state_d;
	bpsc_pkg::back_ctrl_t  ctrl;

	logic [bpsc_pkg::DIV_BITS-1:0] num_q;
	logic [23:0]                rem_q;
	logic [bpsc_pkg::DIV_CW-1:0] cnt_q;
	logic [48:0]                acc_q;
	logic [31:0]                gain_q;
	logic                       out_valid_q;
	logic                       out_free;

	logic [24:0] rem_shift;
	logic        rem_ge;
	logic [23:0] rem_next;
	logic [31:0] newk;
	logic [32:0] mix;
	logic [31:0] gain_sat;
	logic [31:0] gain_next;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign job_pop  = ctrl.pop;

	always_comb begin
		rem_shift = {rem_q, num_q[bpsc_pkg::DIV_BITS-1]};
		rem_ge    = rem_shift >= {1'b0, job.area};
		rem_next  = rem_ge ? 24'(rem_shift - {1'b0, job.area}) : rem_shift[23:0];
		newk      = (|num_q[bpsc_pkg::DIV_BITS-1:32]) ? 32'hFFFF_FFFF : num_q[31:0];
		mix       = acc_q[48:16];
		gain_sat  = mix[32] ? 32'hFFFF_FFFF : mix[31:0];
		gain_next = ctrl.gain_update ? gain_sat : gain_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpsc_pkg::BK_IDLE: begin
				if (job_valid && out_free && job.cal == bpsc_pkg::CAL_UPDATE) begin
					state_d = bpsc_pkg::BK_DIV;
				end
			end
			bpsc_pkg::BK_DIV: begin
				if (cnt_q == bpsc_pkg::DIV_LAST) begin
					state_d = bpsc_pkg::BK_MUL_OLD;
				end
			end
			bpsc_pkg::BK_MUL_OLD: state_d = bpsc_pkg::BK_MUL_NEW;
			bpsc_pkg::BK_MUL_NEW: state_d = bpsc_pkg::BK_FINISH;
			bpsc_pkg::BK_FINISH:  state_d = bpsc_pkg::BK_IDLE;
			default:              state_d = bpsc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			bpsc_pkg::BK_IDLE: begin
				if (job_valid && out_free) begin
					if (job.cal == bpsc_pkg::CAL_UPDATE) begin
						ctrl.div_load = 1'b1;
					end else begin
						ctrl.out_load = 1'b1;
						ctrl.pop      = 1'b1;
					end
				end
			end
			bpsc_pkg::BK_FINISH: begin
				ctrl.out_load    = 1'b1;
				ctrl.pop         = 1'b1;
				ctrl.gain_update = 1'b1;
			end
			default: ;
		endcase
	end

	// restoring divide, one quotient bit per cycle; blend in two multiply steps
	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			num_q <= {1'b0, job.setpoint, 24'd0} + {18'd0, job.area[23:1]};
			rem_q <= 24'd0;
		end else if (state_q == bpsc_pkg::BK_DIV) begin
			num_q <= {num_q[bpsc_pkg::DIV_BITS-2:0], rem_ge};
			rem_q <= rem_next;
		end
		if (state_q == bpsc_pkg::BK_MUL_OLD) begin
			acc_q <= ({33'd0, bpsc_pkg::W_OLD} * {17'd0, gain_q}) + bpsc_pkg::MIX_ROUND;
		end else if (state_q == bpsc_pkg::BK_MUL_NEW) begin
			acc_q <= acc_q + ({35'd0, bpsc_pkg::W_NEW} * {17'd0, newk});
		end
		if (ctrl.out_load) begin
			freq_index       <= job.freq_index;
			pulse_index      <= job.pulse_index;
			current_setpoint <= job.setpoint;
			area_gain        <= gain_next;
			pwm_reapply      <= job.reapply;
			cal_status       <= job.cal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpsc_pkg::BK_IDLE;
			cnt_q       <= '0;
			gain_q      <= bpsc_pkg::GAIN_ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.div_load) begin
				cnt_q <= '0;
			end else if (state_q == bpsc_pkg::BK_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			gain_q <= gain_next;
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/button_panel_setpoint_calibrator_top.sv @@
// ----------------------------------------------------------------------------
// button_panel_setpoint_calibrator_top: button panel with gain calibration
// Each pushed word is one 10 ms tick of five raw button levels and the pulse
// area; each popped word is the panel state after that tick.
// ----------------------------------------------------------------------------
// A tick is taken by the front end in the cycle it is pushed and is written
// into the job queue, then into the result register; with pop held high, plain
// ticks stream at one per cycle. A tick with a calibration update holds the back
// end through dispatch, the one-bit-per-cycle restoring divider, the two blend
// multiplies and write-back. The two-word job queue keeps the push side open
// during that time until it fills. Configuration writes are always ready and
// take effect on the next tick.
module button_panel_setpoint_calibrator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bpsc_pkg::CFG_AW-1:0] cfg_index,
	input  logic [bpsc_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic                        raw_freq,
	input  logic                        raw_pulse,
	input  logic                        raw_up,
	input  logic                        raw_down,
	input  logic                        raw_cal,
	input  logic [23:0]                 pulse_area,
	output logic                        empty,
	input  logic                        pop,
	output logic [3:0]                  freq_index,
	output logic [3:0]                  pulse_index,
	output logic [15:0]                 current_setpoint,
	output logic [31:0]                 area_gain,
	output logic                        pwm_reapply,
	output logic [1:0]                  cal_status
);

	bpsc_pkg::job_t front_job, head_job;
	logic accept;
	logic head_valid;
	logic head_pop;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	bpsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.raw_freq   (raw_freq),
		.raw_pulse  (raw_pulse),
		.raw_up     (raw_up),
		.raw_down   (raw_down),
		.raw_cal    (raw_cal),
		.pulse_area (pulse_area),
		.job        (front_job)
	);

	bpsc_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.wr_data (front_job),
		.pop     (head_pop),
		.full    (full),
		.valid   (head_valid),
		.rd_data (head_job)
	);

	bpsc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job_valid        (head_valid),
		.job              (head_job),
		.job_pop          (head_pop),
		.pop              (pop),
		.empty            (empty),
		.freq_index       (freq_index),
		.pulse_index      (pulse_index),
		.current_setpoint (current_setpoint),
		.area_gain        (area_gain),
		.pwm_reapply      (pwm_reapply),
		.cal_status       (cal_status)
	);

endmodule

@@ hw/rtl/bpsc_checker.sv @@
// ----------------------------------------------------------------------------
// bpsc_checker: port-level checks for the button panel calibrator
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module bpsc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [15:0]                 current_setpoint,
	input logic [31:0]                 area_gain,
	input logic [1:0]                  cal_status
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result side not empty after reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(area_gain) && $stable(current_setpoint)
			&& $stable(cal_status)))
		else $error("waiting result word changed or vanished");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cal_status == bpsc_pkg::CAL_NONE || cal_status == bpsc_pkg::CAL_UPDATE
			|| cal_status == bpsc_pkg::CAL_IGNORED))
		else $error("result word carries an undefined calibration status");

	a_gain_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop && cal_status != bpsc_pkg::CAL_UPDATE) |=> $stable(area_gain))
		else $error("gain moved on a word without calibration update");

endmodule

bind button_panel_setpoint_calibrator_top bpsc_checker u_bpsc_checker (.*);

@@ bench/panel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_checker: result predictor and scoreboard for the button panel
// Follows the register writes and the accepted ticks, predicts the panel
// state after each tick and compares every popped result word with it.
// ----------------------------------------------------------------------------
module panel_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [bpsc_pkg::CFG_AW-1:0] cfg_index,
	input  logic [bpsc_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        push,
	input  logic                        full,
	input  logic                        raw_freq,
	input  logic                        raw_pulse,
	input  logic                        raw_up,
	input  logic                        raw_down,
	input  logic                        raw_cal,
	input  logic [23:0]                 pulse_area,
	input  logic                        empty,
	input  logic                        pop,
	input  logic [3:0]                  freq_index,
	input  logic [3:0]                  pulse_index,
	input  logic [15:0]                 current_setpoint,
	input  logic [31:0]                 area_gain,
	input  logic                        pwm_reapply,
	input  logic [1:0]                  cal_status,
	output int                          errors,
	output int                          pending
);
	import bpsc_pkg::*;

	localparam longint unsigned KEEP_W  = 64'd55706;
	localparam longint unsigned BLEND_W = 64'd9830;
	localparam logic [31:0] UNITY_GAIN  = 32'h0100_0000;
	localparam logic [23:0] UNIT_AREA   = 24'd256;

	typedef struct packed {
		logic [3:0]  freq_index;
		logic [3:0]  pulse_index;
		logic [15:0] setpoint;
		logic [31:0] gain;
		logic        reapply;
		cal_kind_t   cal;
	} panel_word_t;

	logic [4:0]  freq_cnt;
	logic [4:0]  pulse_cnt;
	logic [3:0]  deb_ticks;
	logic [15:0] sp_step;
	logic [15:0] sp_lo;
	logic [15:0] sp_hi;

	logic [NUM_BTN-1:0] last_lvl;
	logic [NUM_BTN-1:0] stable_lvl;
	logic [3:0]         hold_cnt [NUM_BTN];
	logic [3:0]         freq_sel;
	logic [3:0]         pulse_sel;
	logic [15:0]        setpoint;
	logic [31:0]        gain;

	panel_word_t panel_due [$];
	panel_word_t got;
	panel_word_t want;
	logic        bad;
	int          fail_cnt;
	int          word_cnt;

	function automatic logic press_edge(input int b, input logic lvl);
		if (lvl == last_lvl[b]) begin
			if (hold_cnt[b] < deb_ticks) begin
				hold_cnt[b] = hold_cnt[b] + 4'd1;
			end
		end else begin
			hold_cnt[b] = 4'd0;
			last_lvl[b] = lvl;
		end
		if (hold_cnt[b] == deb_ticks && stable_lvl[b] != lvl) begin
			stable_lvl[b] = lvl;
			return lvl;
		end
		return 1'b0;
	endfunction

	function automatic logic [3:0] next_index(input logic [3:0] sel, input logic [4:0] count);
		int n;
		n = int'(sel) + 1;
		if (n >= int'(count) || n >= TABLE_ENTRIES || n > 15) begin
			n = 0;
		end
		return n[3:0];
	endfunction

	function automatic logic [15:0] bound_setpoint(input int x);
		if (x < int'(sp_lo)) begin
			return sp_lo;
		end
		if (x > int'(sp_hi)) begin
			return sp_hi;
		end
		return x[15:0];
	endfunction

	function automatic panel_word_t apply_tick(input logic [4:0] btn, input logic [23:0] area);
		panel_word_t w;
		longint unsigned quot;
		longint unsigned mix;
		w.reapply = 1'b0;
		w.cal = CAL_NONE;
		if (press_edge(BTN_FREQ, btn[BTN_FREQ])) begin
			freq_sel = next_index(freq_sel, freq_cnt);
			w.reapply = 1'b1;
		end
		if (press_edge(BTN_PULSE, btn[BTN_PULSE])) begin
			pulse_sel = next_index(pulse_sel, pulse_cnt);
			w.reapply = 1'b1;
		end
		if (press_edge(BTN_UP, btn[BTN_UP])) begin
			setpoint = bound_setpoint(int'(setpoint) + int'(sp_step));
		end
		if (press_edge(BTN_DOWN, btn[BTN_DOWN])) begin
			setpoint = bound_setpoint(int'(setpoint) - int'(sp_step));
		end
		if (press_edge(BTN_CAL, btn[BTN_CAL])) begin
			if (area > UNIT_AREA) begin
				quot = 64'(setpoint) << 24;
				quot = (quot + 64'(area >> 1)) / 64'(area);
				if (quot > 64'hFFFF_FFFF) begin
					quot = 64'hFFFF_FFFF;
				end
				mix = (KEEP_W * 64'(gain) + BLEND_W * quot + 64'd32768) >> 16;
				if (mix > 64'hFFFF_FFFF) begin
					mix = 64'hFFFF_FFFF;
				end
				gain = mix[31:0];
				w.cal = CAL_UPDATE;
			end else begin
				w.cal = CAL_IGNORED;
			end
		end
		w.freq_index = freq_sel;
		w.pulse_index = pulse_sel;
		w.setpoint = setpoint;
		w.gain = gain;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_cnt = 5'd4;
			pulse_cnt = 5'd4;
			deb_ticks = 4'd3;
			sp_step = 16'd128;
			sp_lo = 16'd0;
			sp_hi = 16'd5120;
			last_lvl = '0;
			stable_lvl = '0;
			for (int b = 0; b < NUM_BTN; b++) begin
				hold_cnt[b] = 4'd0;
			end
			freq_sel = 4'd0;
			pulse_sel = 4'd0;
			setpoint = 16'd0;
			gain = UNITY_GAIN;
			panel_due.delete();
			fail_cnt = 0;
			word_cnt = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FREQ_COUNT:     freq_cnt = cfg_data[4:0];
					CFG_PULSE_COUNT:    pulse_cnt = cfg_data[4:0];
					CFG_DEBOUNCE_TICKS: deb_ticks = cfg_data[3:0];
					CFG_CURRENT_STEP:   sp_step = cfg_data;
					CFG_CURRENT_MIN:    sp_lo = cfg_data;
					CFG_CURRENT_MAX:    sp_hi = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				got = {freq_index, pulse_index, current_setpoint, area_gain, pwm_reapply,
					cal_status};
				if (panel_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10) begin
						$display("result word %0d popped with nothing expected: %h", word_cnt, got);
					end
				end else begin
					want = panel_due.pop_front();
					bad = 1'b0;
					if (want.freq_index !== got.freq_index) bad = 1'b1;
					if (want.pulse_index !== got.pulse_index) bad = 1'b1;
					if (want.setpoint !== got.setpoint) bad = 1'b1;
					if (want.gain !== got.gain) bad = 1'b1;
					if (want.reapply !== got.reapply) bad = 1'b1;
					if (want.cal !== got.cal) bad = 1'b1;
					if (bad) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display({"result word %0d mismatch: exp freq=%0d pulse=%0d sp=%h ",
								"gain=%h reapply=%0b cal=%0d, got freq=%0d pulse=%0d sp=%h ",
								"gain=%h reapply=%0b cal=%0d"}, word_cnt,
								want.freq_index, want.pulse_index, want.setpoint, want.gain,
								want.reapply, want.cal, got.freq_index, got.pulse_index,
								got.setpoint, got.gain, got.reapply, got.cal);
						end
					end
				end
				word_cnt++;
			end
			if (push && !full) begin
				panel_due.push_back(apply_tick({raw_cal, raw_down, raw_up, raw_pulse, raw_freq},
					pulse_area));
			end
		end
		errors <= fail_cnt;
		pending <= panel_due.size();
	end

endmodule

@@ bench/button_panel_setpoint_calibrator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_panel_setpoint_calibrator_top_tb: testbench for the button panel
// Drives directed and random button tick streams under several register
// settings with random gaps and stalls on both sides; the checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module button_panel_setpoint_calibrator_top_tb;
	import bpsc_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 64;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_AW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;
	logic                push;
	logic                full;
	logic                raw_freq;
	logic                raw_pulse;
	logic                raw_up;
	logic                raw_down;
	logic                raw_cal;
	logic [23:0]         pulse_area;
	logic                empty;
	logic                pop;
	logic [3:0]          freq_index;
	logic [3:0]          pulse_index;
	logic [15:0]         current_setpoint;
	logic [31:0]         area_gain;
	logic                pwm_reapply;
	logic [1:0]          cal_status;

	int                  errors;
	int                  pending;
	int                  quiet;
	int                  hold_req;
	bit                  push_idle;
	bit                  pop_idle;
	int                  deb_cfg;
	logic [4:0]          lvl_now;
	int                  run_left [NUM_BTN];

	button_panel_setpoint_calibrator_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.push             (push),
		.full             (full),
		.raw_freq         (raw_freq),
		.raw_pulse        (raw_pulse),
		.raw_up           (raw_up),
		.raw_down         (raw_down),
		.raw_cal          (raw_cal),
		.pulse_area       (pulse_area),
		.empty            (empty),
		.pop              (pop),
		.freq_index       (freq_index),
		.pulse_index      (pulse_index),
		.current_setpoint (current_setpoint),
		.area_gain        (area_gain),
		.pwm_reapply      (pwm_reapply),
		.cal_status       (cal_status)
	);

	panel_checker panel_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.push             (push),
		.full             (full),
		.raw_freq         (raw_freq),
		.raw_pulse        (raw_pulse),
		.raw_up           (raw_up),
		.raw_down         (raw_down),
		.raw_cal          (raw_cal),
		.pulse_area       (pulse_area),
		.empty            (empty),
		.pop              (pop),
		.freq_index       (freq_index),
		.pulse_index      (pulse_index),
		.current_setpoint (current_setpoint),
		.area_gain        (area_gain),
		.pwm_reapply      (pwm_reapply),
		.cal_status       (cal_status),
		.errors           (errors),
		.pending          (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("button_panel_setpoint_calibrator_top_tb: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_panel(input logic [4:0] fc, input logic [4:0] pc, input logic [3:0] db,
		input logic [15:0] stp, input logic [15:0] lo, input logic [15:0] hi);
		write_reg(CFG_FREQ_COUNT, {11'd0, fc});
		write_reg(CFG_PULSE_COUNT, {11'd0, pc});
		write_reg(CFG_DEBOUNCE_TICKS, {12'd0, db});
		write_reg(CFG_CURRENT_STEP, stp);
		write_reg(CFG_CURRENT_MIN, lo);
		write_reg(CFG_CURRENT_MAX, hi);
		deb_cfg = int'(db);
	endtask

	task automatic send_tick(input logic [4:0] btn, input logic [23:0] area);
		int gap;
		gap = push_idle ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{raw_cal, raw_down, raw_up, raw_pulse, raw_freq} = btn;
		pulse_area = area;
		push = 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic press(input logic [4:0] btn, input logic [23:0] area, input int n);
		repeat (n) send_tick(btn, area);
	endtask

	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic random_ticks(input int n);
		logic [4:0]  btn;
		logic [23:0] area;
		repeat (n) begin
			for (int b = 0; b < NUM_BTN; b++) begin
				if (run_left[b] <= 0) begin
					lvl_now[b] = ~lvl_now[b];
					if ($urandom_range(0, 3) == 0) begin
						run_left[b] = $urandom_range(1, deb_cfg + 1);
					end else begin
						run_left[b] = deb_cfg + 1 + $urandom_range(0, 4);
					end
				end
				run_left[b]--;
			end
			btn = lvl_now;
			if ($urandom_range(0, 9) == 0) begin
				btn = 5'($urandom);
			end
			case ($urandom_range(0, 5))
				0: area = 24'($urandom_range(0, 256));
				1: area = 24'($urandom_range(257, 1023));
				2: area = 24'($urandom);
				3: area = 24'hFF_FFFF;
				default: area = 24'($urandom_range(256, 65535));
			endcase
			send_tick(btn, area);
		end
	endtask

	initial begin
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				pop = 1'b0;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
			end
			stall = pop_idle ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				pop = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop = 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] tmp;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FREQ_COUNT;
		cfg_data = '0;
		push = 1'b0;
		{raw_cal, raw_down, raw_up, raw_pulse, raw_freq} = 5'b00000;
		pulse_area = 24'd0;
		hold_req = 0;
		push_idle = 1'b1;
		pop_idle = 1'b1;
		quiet = 0;
		lvl_now = 5'b00000;
		for (int b = 0; b < NUM_BTN; b++) begin
			run_left[b] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_panel(5'd2, 5'd1, 4'd1, 16'hFFFF, 16'd0, 16'hFFFF);
		press(5'b11111, 24'hFF_FFFF, 2);
		press(5'b00000, 24'h00_0000, 2);
		press(5'b00100, 24'h00_0001, 2);
		press(5'b00000, 24'h00_0000, 2);
		press(5'b00100, 24'h00_0000, 2);
		press(5'b10000, 24'h00_0100, 2);
		press(5'b00000, 24'h00_0000, 2);
		press(5'b10000, 24'h00_0101, 2);
		press(5'b00000, 24'h00_0000, 2);
		press(5'b00010, 24'h80_0000, 1);
		press(5'b00011, 24'h7F_FFFF, 2);
		press(5'b01000, 24'hFF_FFFF, 2);
		settle();

		for (int p = 1; p <= 8; p++) begin
			push_idle = p[0];
			pop_idle = p[1] | p[2];
			case (p)
				1: set_panel(5'd31, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF, 16'h0000);
				2: set_panel(5'd0, 5'd0, 4'd0, 16'd1, 16'd0, 16'hFFFF);
				3: set_panel(5'd1, 5'd16, 4'd1, 16'd256, 16'd1000, 16'd4000);
				4: set_panel(5'd16, 5'd17, 4'd2, 16'($urandom), 16'd0, 16'hFFFF);
				default: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
					if (p != 7 && lo > hi) begin
						tmp = lo;
						lo = hi;
						hi = tmp;
					end
					set_panel(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
						4'($urandom_range(0, 4)), 16'($urandom_range(0, 4095)), lo, hi);
				end
			endcase
			if (p == 3) begin
				push_idle = 1'b0;
				pop_idle = 1'b0;
				hold_req = 200;
			end
			random_ticks(100);
			settle();
		end

		if (errors == 0 && pending == 0) begin
			$display("button_panel_setpoint_calibrator_top_tb: done, clean");
		end else begin
			$display("button_panel_setpoint_calibrator_top_tb: done, errors");
		end
		$finish;
	end

endmodule
